[sv/dbgf_pkg.sv]
// shared constants and types of the depth band free gap finder
`default_nettype none

package dbgf_pkg;

  // parameter defaults
  localparam int MAX_COLS_DEF = 256;
  localparam int TOP_N_DEF    = 2;

  // field and state widths
  localparam int DEPTH_W   = 14;
  localparam int SUM_W     = 22;
  localparam int ROW_W     = 9;
  localparam int FW_W      = 9;
  localparam int BF_W      = 8;
  localparam int BE_W      = 9;
  localparam int NL_W      = 14;
  localparam int NEED_W    = NL_W + ROW_W;
  localparam int GAP_COL_W = 8;
  localparam int GAP_LEN_W = 9;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [ROW_W-1:0] ROW_SAT = '1;

  // stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // register port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [FW_W-1:0] FW_RST = FW_W'(240);
  localparam logic [BF_W-1:0] BF_RST = BF_W'(60);
  localparam logic [BE_W-1:0] BE_RST = BE_W'(120);
  localparam logic [NL_W-1:0] NL_RST = NL_W'(800);

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH = 2'd0,
    REG_BAND_FIRST  = 2'd1,
    REG_BAND_END    = 2'd2,
    REG_NEAR_LIMIT  = 2'd3
  } cfg_reg_e;

  // per pixel control, decided when the item is taken
  typedef struct packed {
    logic in_band;
    logic first_row;
    logic judge;
    logic row_last;
    logic fend;
  } px_ctrl_t;

  // column verdict handed to the ranker
  typedef struct packed {
    logic free;
    logic judge;
    logic row_last;
    logic fend;
  } verdict_t;

  // one ranked result, gap_start in the lowest bits
  typedef struct packed {
    logic [GAP_LEN_W-1:0] gap_length;
    logic [GAP_COL_W-1:0] gap_end;
    logic [GAP_COL_W-1:0] gap_start;
  } gap_rec_t;

endpackage

`default_nettype wire

[sv/dbgf_col_accum.sv]
// column sum memory, band accumulate and free column test
`default_nettype none

module dbgf_col_accum #(
  parameter int MAX_COLS = dbgf_pkg::MAX_COLS_DEF,
  parameter int COL_W    = $clog2(MAX_COLS)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          px_vld_i,
  input  wire  [COL_W-1:0]             px_col_i,
  input  dbgf_pkg::px_ctrl_t           px_ctrl_i,
  input  wire  [dbgf_pkg::DEPTH_W-1:0] px_depth_i,
  input  wire  [dbgf_pkg::NEED_W-1:0]  need_i,
  output logic                         vd_vld_o,
  output dbgf_pkg::verdict_t           vd_o,
  output logic [COL_W-1:0]             vd_col_o,
  output logic                         fend_pend_o
);
  import dbgf_pkg::*;

  logic [SUM_W-1:0] mem_q [MAX_COLS];
  logic [SUM_W-1:0] rd_q;

  logic             s1_vld_q;
  px_ctrl_t         s1_ctrl_q;
  logic [COL_W-1:0] s1_col_q;
  logic [DEPTH_W-1:0] s1_depth_q;
  logic             fwd_q;
  logic [SUM_W-1:0] fwd_sum_q;

  logic [SUM_W-1:0] base;
  logic [SUM_W:0]   sum_raw;
  logic [SUM_W-1:0] sum_d;
  logic             wr_en;
  logic             free;

  logic             vd_vld_q;
  verdict_t         vd_q;
  logic [COL_W-1:0] vd_col_q;

  // previous pixel of the same column written this very edge: take it from the bypass
  assign base    = s1_ctrl_q.first_row ? '0 : (fwd_q ? fwd_sum_q : rd_q);
  assign sum_raw = {1'b0, base} + (SUM_W+1)'(s1_depth_q);
  assign sum_d   = sum_raw[SUM_W] ? SUM_MAX : sum_raw[SUM_W-1:0];
  assign wr_en   = s1_vld_q && s1_ctrl_q.in_band;
  assign free    = (sum_d != '0) && (NEED_W'(sum_d) >= need_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      vd_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= px_vld_i;
      vd_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (px_vld_i) begin
      s1_ctrl_q  <= px_ctrl_i;
      s1_col_q   <= px_col_i;
      s1_depth_q <= px_depth_i;
      rd_q       <= mem_q[px_col_i];
      fwd_q      <= wr_en && (s1_col_q == px_col_i);
      fwd_sum_q  <= sum_d;
    end
    if (wr_en) begin
      mem_q[s1_col_q] <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      vd_q.free     <= free;
      vd_q.judge    <= s1_ctrl_q.in_band && s1_ctrl_q.judge;
      vd_q.row_last <= s1_ctrl_q.row_last;
      vd_q.fend     <= s1_ctrl_q.fend;
      vd_col_q      <= s1_col_q;
    end
  end

  assign vd_vld_o    = vd_vld_q;
  assign vd_o        = vd_q;
  assign vd_col_o    = vd_col_q;
  assign fend_pend_o = (s1_vld_q && s1_ctrl_q.fend) || (vd_vld_q && vd_q.fend);

endmodule

`default_nettype wire

[sv/dbgf_gap_rank.sv]
// run tracking, top gap ranking and result bank
`default_nettype none

module dbgf_gap_rank #(
  parameter int TOP_N = dbgf_pkg::TOP_N_DEF,
  parameter int COL_W = 8
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 vd_vld_i,
  input  dbgf_pkg::verdict_t  vd_i,
  input  wire  [COL_W-1:0]    vd_col_i,
  output logic                bank_busy_o,
  output logic                out_vld_o,
  input  wire                 out_rdy_i,
  output dbgf_pkg::gap_rec_t  out_rec_o,
  output logic                out_present_o,
  output logic                out_last_o
);
  import dbgf_pkg::*;

  localparam int IDX_W = (TOP_N > 1) ? $clog2(TOP_N) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TOP_N - 1);

  logic             prev_q;
  logic [COL_W-1:0] rb_q;
  logic [COL_W-1:0] beg_q  [TOP_N];
  logic [COL_W-1:0] fin_q  [TOP_N];
  logic [TOP_N-1:0] pres_q;
  logic [COL_W:0]   len_q  [TOP_N];

  logic [COL_W-1:0] beg_n  [TOP_N];
  logic [COL_W-1:0] fin_n  [TOP_N];
  logic [TOP_N-1:0] pres_n;
  logic [TOP_N-1:0] ins_at;
  logic [TOP_N-1:0] shift;

  logic             judge, fend, start_run, pf_mid, close_a, close_b, do_rank;
  logic             prev_d;
  logic [COL_W-1:0] rb_mid, r_first, r_last;
  logic [COL_W:0]   r_len;

  gap_rec_t         bank_q  [TOP_N];
  logic [TOP_N-1:0] bank_pres_q;
  logic             bank_vld_q;
  logic [IDX_W-1:0] idx_q;

  // run bookkeeping: a run closes on a blocked column, at row end, or at frame end
  assign judge     = vd_vld_i && vd_i.judge;
  assign fend      = vd_vld_i && vd_i.fend;
  assign start_run = judge && vd_i.free && !prev_q;
  assign rb_mid    = start_run ? vd_col_i : rb_q;
  assign pf_mid    = judge ? vd_i.free : prev_q;
  assign close_a   = judge && !vd_i.free && prev_q;
  assign close_b   = pf_mid && ((judge && vd_i.row_last) || fend);
  assign r_first   = rb_mid;
  assign r_last    = close_a ? (vd_col_i - 1'b1) : vd_col_i;
  assign r_len     = {1'b0, r_last} - {1'b0, r_first} + 1'b1;
  // single columns never count as gaps
  assign do_rank   = (close_a || close_b) && (r_last > r_first);
  assign prev_d    = pf_mid && !(judge && vd_i.row_last) && !fend;

  always_comb begin
    for (int k = 0; k < TOP_N; k++) begin
      len_q[k] = {1'b0, fin_q[k]} - {1'b0, beg_q[k]} + 1'b1;
    end
  end

  // insertion point: first empty rank or first strictly shorter gap
  always_comb begin
    logic seen;
    logic hit;
    seen = 1'b0;
    hit  = 1'b0;
    for (int k = 0; k < TOP_N; k++) begin
      hit       = !pres_q[k] || (r_len > len_q[k]);
      ins_at[k] = do_rank && hit && !seen;
      shift[k]  = do_rank && seen;
      seen      = seen || (do_rank && hit);
    end
  end

  always_comb begin
    beg_n  = beg_q;
    fin_n  = fin_q;
    pres_n = pres_q;
    for (int k = 1; k < TOP_N; k++) begin
      if (shift[k]) begin
        beg_n[k]  = beg_q[k-1];
        fin_n[k]  = fin_q[k-1];
        pres_n[k] = pres_q[k-1];
      end
    end
    for (int k = 0; k < TOP_N; k++) begin
      if (ins_at[k]) begin
        beg_n[k]  = r_first;
        fin_n[k]  = r_last;
        pres_n[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= 1'b0;
      rb_q       <= '0;
      pres_q     <= '0;
      bank_vld_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      if (vd_vld_i) begin
        prev_q <= prev_d;
        rb_q   <= fend ? '0 : rb_mid;
        pres_q <= fend ? '0 : pres_n;
      end
      if (fend) begin
        bank_vld_q <= 1'b1;
        idx_q      <= '0;
      end else if (bank_vld_q && out_rdy_i) begin
        if (idx_q == IDX_LAST) begin
          bank_vld_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vd_vld_i) begin
      beg_q <= beg_n;
      fin_q <= fin_n;
    end
    if (fend) begin
      bank_pres_q <= pres_n;
      for (int k = 0; k < TOP_N; k++) begin
        if (pres_n[k]) begin
          bank_q[k].gap_start  <= GAP_COL_W'(beg_n[k]);
          bank_q[k].gap_end    <= GAP_COL_W'(fin_n[k]);
          bank_q[k].gap_length <= GAP_LEN_W'({1'b0, fin_n[k]} - {1'b0, beg_n[k]} + 1'b1);
        end else begin
          bank_q[k] <= '0;
        end
      end
    end
  end

  assign bank_busy_o   = bank_vld_q;
  assign out_vld_o     = bank_vld_q;
  assign out_rec_o     = bank_q[idx_q];
  assign out_present_o = bank_pres_q[idx_q];
  assign out_last_o    = (idx_q == IDX_LAST);

endmodule

`default_nettype wire

[sv/depth_band_free_gap_finder.sv]
// top level of the depth band free gap finder: register port, raster counters, pipeline
`default_nettype none

// Depth pixels come in raster order, one item per clock but for held-off frame ends. Each column
// is summed over the rows band_first_row up to band_end_row (exclusive) in a one-read one-write
// column memory; on the last band row a column is free when its sum is non-zero and at least
// near_limit times the band height. Runs of two or more free columns are gaps; the TOP_N longest
// (ties keep the earlier start) are sent as TOP_N consecutive result items, rank 0 first, the
// first one once the frame end has reached the result bank, tlast on the last rank and tuser set
// where the rank holds a gap. Throughput is one pixel per cycle but for held-off frame ends, set
// by the read-modify-write of the column memory (a bypass covers a one-column frame). A
// frame-end pixel is held off while the previous frame's results are still in the pipeline or
// waiting in the result bank, so a stalled result port slows only the next frame end. The memory
// needs no clearing after reset: the first band row writes every column before any read.

module depth_band_free_gap_finder #(
  parameter int MAX_COLS = dbgf_pkg::MAX_COLS_DEF,
  parameter int TOP_N    = dbgf_pkg::TOP_N_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // pixel stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [dbgf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // depth_mm[13:0], zero pad
  input  wire                               s_axis_tlast,   // frame_end
  // ranked gap stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [dbgf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // gap_start, gap_end, gap_length
  output logic                              m_axis_tuser,   // gap_valid
  output logic                              m_axis_tlast,   // last_gap
  // register port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [dbgf_pkg::CFG_AW-1:0]       paddr,
  input  wire  [dbgf_pkg::CFG_DW-1:0]       pwdata,
  output logic [dbgf_pkg::CFG_DW-1:0]       prdata,
  output logic                              pready
);
  import dbgf_pkg::*;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam int WCMP_W = (CNT_W > FW_W) ? CNT_W : FW_W;

  // configuration registers
  logic [FW_W-1:0]   frame_width_q;
  logic [BF_W-1:0]   band_first_q;
  logic [BE_W-1:0]   band_end_q;
  logic [NL_W-1:0]   near_limit_q;
  logic [NEED_W-1:0] need_q, need_d;
  logic [ROW_W-1:0]  rows;
  logic              cfg_wr;
  cfg_reg_e          cfg_idx;

  // raster position
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [WCMP_W-1:0] fw_ext, width_act;
  px_ctrl_t          px_ctrl;
  logic              accept;

  // pipeline links
  logic              vd_vld;
  verdict_t          vd;
  logic [COL_W-1:0]  vd_col;
  logic              fend_pend;
  logic              bank_busy;
  gap_rec_t          out_rec;
  logic              out_present;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= FW_RST;
      band_first_q  <= BF_RST;
      band_end_q    <= BE_RST;
      near_limit_q  <= NL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH: frame_width_q <= pwdata[FW_W-1:0];
        REG_BAND_FIRST:  band_first_q  <= pwdata[BF_W-1:0];
        REG_BAND_END:    band_end_q    <= pwdata[BE_W-1:0];
        REG_NEAR_LIMIT:  near_limit_q  <= pwdata[NL_W-1:0];
        default:         frame_width_q <= frame_width_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH: prdata = CFG_DW'(frame_width_q);
      REG_BAND_FIRST:  prdata = CFG_DW'(band_first_q);
      REG_BAND_END:    prdata = CFG_DW'(band_end_q);
      REG_NEAR_LIMIT:  prdata = CFG_DW'(near_limit_q);
      default:         prdata = '0;
    endcase
  end

  // free threshold: band sum against near_limit times band height, kept registered
  // (only used when the band is non-empty, so the wrapped height does not matter)
  assign rows   = band_end_q - ROW_W'(band_first_q);
  assign need_d = NEED_W'(near_limit_q) * NEED_W'(rows);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= NEED_W'(NL_RST) * NEED_W'(BE_RST - ROW_W'(BF_RST));
    end else begin
      need_q <= need_d;
    end
  end

  // ---------------- raster counters ----------------
  // zero width acts as one column, anything wider than the memory as the memory
  assign fw_ext = WCMP_W'(frame_width_q);

  always_comb begin
    priority if (fw_ext == '0) begin
      width_act = WCMP_W'(1);
    end else if (fw_ext > WCMP_W'(MAX_COLS)) begin
      width_act = WCMP_W'(MAX_COLS);
    end else begin
      width_act = fw_ext;
    end
  end

  // a lowered width ends the current row at once
  assign px_ctrl.row_last  = (WCMP_W'(col_q) + 1'b1) >= width_act;
  assign px_ctrl.in_band   = (row_q >= ROW_W'(band_first_q)) && (row_q < band_end_q);
  assign px_ctrl.first_row = (row_q == ROW_W'(band_first_q));
  assign px_ctrl.judge     = ({1'b0, row_q} + 1'b1) == {1'b0, band_end_q};
  assign px_ctrl.fend      = s_axis_tlast;

  // a frame end waits until the previous frame's results have left
  assign s_axis_tready = !(s_axis_tlast && (fend_pend || bank_busy));
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (s_axis_tlast) begin
      row_d = '0;
      col_d = '0;
    end else if (px_ctrl.row_last) begin
      col_d = '0;
      if (row_q != ROW_SAT) begin
        row_d = row_q + 1'b1;
      end
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ---------------- column accumulate and test ----------------
  dbgf_col_accum #(
    .MAX_COLS (MAX_COLS),
    .COL_W    (COL_W)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .px_vld_i    (accept),
    .px_col_i    (col_q),
    .px_ctrl_i   (px_ctrl),
    .px_depth_i  (s_axis_tdata[DEPTH_W-1:0]),
    .need_i      (need_q),
    .vd_vld_o    (vd_vld),
    .vd_o        (vd),
    .vd_col_o    (vd_col),
    .fend_pend_o (fend_pend)
  );

  // ---------------- gap ranking and results ----------------
  dbgf_gap_rank #(
    .TOP_N (TOP_N),
    .COL_W (COL_W)
  ) u_rank (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vd_vld_i      (vd_vld),
    .vd_i          (vd),
    .vd_col_i      (vd_col),
    .bank_busy_o   (bank_busy),
    .out_vld_o     (m_axis_tvalid),
    .out_rdy_i     (m_axis_tready),
    .out_rec_o     (out_rec),
    .out_present_o (out_present),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDATA_W'(out_rec);
  assign m_axis_tuser = out_present;

endmodule

`default_nettype wire

[bench/testbench.sv]
// self-checking bench for the depth band free gap finder: pixel frames in, ranked gaps checked
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dbgf_pkg::*;

  localparam int COLS        = MAX_COLS_DEF;
  localparam int RANKS       = TOP_N_DEF;
  localparam int DEPTH_MAX   = (1 << DEPTH_W) - 1;
  localparam int IDLE_MAX    = 6;
  localparam int HOLD_CYCLES = 300;   // long result-side hold-off
  localparam int DRAIN_WAIT  = 8;     // lets the pipeline run dry after the last due result
  localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
  localparam int ITEM_TARGET = 250;   // pixels over the whole run
  localparam int RAND_FRAMES = 6;

  // one ranked gap as it should leave the block
  typedef struct packed {
    gap_rec_t rec;
    logic     present;
    logic     last_rank;
  } gap_due_t;

  // predictor of the column band sums, free runs and the gap ranking, plus the result check
  class gap_rank_board;
    int unsigned width_reg, first_reg, end_reg, limit_reg;
    int unsigned col_sum[COLS];
    int unsigned row_idx, col_idx, run_start;
    bit          in_run;
    int unsigned top_start[RANKS], top_end[RANKS];
    bit          top_used[RANKS];
    gap_due_t    due_gaps[$];
    int          errors, seen, with_gap, pixels, frames;

    function new();
      width_reg = FW_RST;
      first_reg = BF_RST;
      end_reg   = BE_RST;
      limit_reg = NL_RST;
      foreach (col_sum[i]) col_sum[i] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      row_idx   = 0;
      col_idx   = 0;
      in_run    = 1'b0;
      run_start = 0;
      foreach (top_used[k]) begin
        top_start[k] = 0;
        top_end[k]   = 0;
        top_used[k]  = 1'b0;
      end
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DW-1:0] v);
      case (idx)
        REG_FRAME_WIDTH: width_reg = v[FW_W-1:0];
        REG_BAND_FIRST:  first_reg = v[BF_W-1:0];
        REG_BAND_END:    end_reg   = v[BE_W-1:0];
        REG_NEAR_LIMIT:  limit_reg = v[NL_W-1:0];
      endcase
    endfunction

    function int unsigned reg_value(cfg_reg_e idx);
      case (idx)
        REG_FRAME_WIDTH: return width_reg;
        REG_BAND_FIRST:  return first_reg;
        REG_BAND_END:    return end_reg;
        default:         return limit_reg;
      endcase
    endfunction

    function int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > COLS) return COLS;
      return width_reg;
    endfunction

    // insert a run into the ranking, longer first, equal lengths keep the earlier start ahead
    function void add_gap(int unsigned lo, int unsigned hi);
      int unsigned len;
      int k;
      if (hi <= lo) return;
      len = hi - lo + 1;
      for (k = 0; k < RANKS; k++) begin
        if (!top_used[k]) break;
        if (len > top_end[k] - top_start[k] + 1) break;
      end
      if (k >= RANKS) return;
      for (int j = RANKS - 1; j > k; j--) begin
        top_start[j] = top_start[j-1];
        top_end[j]   = top_end[j-1];
        top_used[j]  = top_used[j-1];
      end
      top_start[k] = lo;
      top_end[k]   = hi;
      top_used[k]  = 1'b1;
    endfunction

    function void take_pixel(logic [DEPTH_W-1:0] depth, logic fend);
      int unsigned c, s, need;
      bit row_done, band;
      gap_due_t g;
      pixels++;
      c        = col_idx;
      row_done = (c + 1 >= active_width());
      band     = (row_idx >= first_reg) && (row_idx < end_reg);
      if (c >= COLS) c = COLS - 1;
      if (band) begin
        s = (row_idx == first_reg) ? 0 : col_sum[c];
        s += depth;
        if (s > SUM_MAX) s = SUM_MAX;
        col_sum[c] = s;
        // judging row: average >= limit, checked as sum >= limit * band height
        if (row_idx + 1 == end_reg) begin
          need = limit_reg * (end_reg - first_reg);
          if (s > 0 && s >= need) begin
            if (!in_run) run_start = c;
            in_run = 1'b1;
          end else if (in_run) begin
            add_gap(run_start, c - 1);
            in_run = 1'b0;
          end
          if (row_done && in_run) begin
            add_gap(run_start, c);
            in_run = 1'b0;
          end
        end
      end
      if (row_done) begin
        col_idx = 0;
        if (row_idx < ROW_SAT) row_idx++;
      end else begin
        col_idx = c + 1;
      end
      if (!fend) return;
      // frame end inside the judging row closes the open run here
      if (in_run) add_gap(run_start, c);
      for (int k = 0; k < RANKS; k++) begin
        g.rec.gap_start  = top_used[k] ? GAP_COL_W'(top_start[k]) : '0;
        g.rec.gap_end    = top_used[k] ? GAP_COL_W'(top_end[k]) : '0;
        g.rec.gap_length = top_used[k] ? GAP_LEN_W'(top_end[k] - top_start[k] + 1) : '0;
        g.present        = top_used[k];
        g.last_rank      = (k == RANKS - 1);
        due_gaps = {due_gaps, g};
      end
      frames++;
      clear_frame();
    endfunction

    function void check_gap(logic [OUT_TDATA_W-1:0] data, logic user, logic last);
      gap_due_t e;
      gap_rec_t got;
      got = data[$bits(gap_rec_t)-1:0];
      seen++;
      if (user === 1'b1) with_gap++;
      if (due_gaps.size() == 0) begin
        $error("gap item with nothing due: tdata %h tuser %b tlast %b", data, user, last);
        errors++;
        return;
      end
      e = due_gaps.pop_front();
      if (got.gap_start !== e.rec.gap_start) begin
        $error("gap_start expected %0d got %0d", e.rec.gap_start, got.gap_start);
        errors++;
      end
      if (got.gap_end !== e.rec.gap_end) begin
        $error("gap_end expected %0d got %0d", e.rec.gap_end, got.gap_end);
        errors++;
      end
      if (got.gap_length !== e.rec.gap_length) begin
        $error("gap_length expected %0d got %0d", e.rec.gap_length, got.gap_length);
        errors++;
      end
      if (data[OUT_TDATA_W-1:$bits(gap_rec_t)] !== '0) begin
        $error("tdata padding expected 0 got %h", data[OUT_TDATA_W-1:$bits(gap_rec_t)]);
        errors++;
      end
      if (user !== e.present) begin
        $error("gap_valid expected %b got %b", e.present, user);
        errors++;
      end
      if (last !== e.last_rank) begin
        $error("last_gap expected %b got %b", e.last_rank, last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [CFG_AW-1:0]      paddr         = '0;
  logic [CFG_DW-1:0]      pwdata        = '0;
  logic [CFG_DW-1:0]      prdata;
  logic                   pready;

  gap_rank_board          board;
  bit                     idle_on       = 1'b0;  // both sides draw random gaps when set
  bit                     choke_req     = 1'b0;  // asks the result side for one long hold-off
  int                     idle_cycles   = 0;
  int                     cfg_sets      = 0;
  logic [DEPTH_W-1:0]     col_depth[COLS];       // per column depth of fixed-pattern frames
  bit                     col_open[COLS];        // per column free bias of random frames

  depth_band_free_gap_finder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog: ends the run when no handshake of any kind happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d gap items still due",
               STALL_LIMIT, board.due_gaps.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random ready gaps per item, one long hold-off on request
  initial begin : result_sink
    int hold;
    wait (rst_ni === 1'b1);
    forever begin
      hold = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (choke_req) begin
        hold      = HOLD_CYCLES;
        choke_req = 1'b0;
      end
      repeat (hold) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_gap(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  task automatic apb_xfer(input bit wr, input cfg_reg_e idx, input logic [CFG_DW-1:0] wdata,
                          output logic [CFG_DW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input cfg_reg_e idx);
    logic [CFG_DW-1:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== CFG_DW'(board.reg_value(idx))) begin
      $error("register %s expected %0d got %0d", idx.name(), board.reg_value(idx), rd);
      board.errors++;
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned v);
    logic [CFG_DW-1:0] rd;
    apb_xfer(1'b1, idx, CFG_DW'(v), rd);
    board.set_reg(idx, CFG_DW'(v));
    check_reg(idx);
  endtask

  task automatic set_cfg(input int unsigned fw, input int unsigned bf, input int unsigned be,
                         input int unsigned nl);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_BAND_FIRST, bf);
    write_reg(REG_BAND_END, be);
    write_reg(REG_NEAR_LIMIT, nl);
    cfg_sets++;
  endtask

  // stop offering pixels, let every due result arrive, then let the pipeline run dry
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.due_gaps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic fend);
    int gap;
    gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(depth);
    s_axis_tlast  <= fend;
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_pixel(depth, fend);
  endtask

  task automatic fill_columns(input logic [COLS-1:0] mask, input int unsigned hi);
    foreach (col_depth[c]) col_depth[c] = mask[c] ? DEPTH_W'(hi) : '0;
  endtask

  // one frame of n_rows rows; cut > 0 puts frame end on that pixel count, cut < 0 picks one
  task automatic send_frame(input bit fixed, input int n_rows, input int cut);
    int eff, n_pix, c, r;
    int unsigned v;
    logic [DEPTH_W-1:0] d;
    eff   = board.active_width();
    n_pix = eff * n_rows;
    if (cut < 0) cut = $urandom_range(1, n_pix);
    if (cut > 0 && cut < n_pix) n_pix = cut;
    // free bias comes in runs so that gaps of several lengths show up
    col_open[0] = $urandom_range(0, 1);
    for (c = 1; c < COLS; c++)
      col_open[c] = ($urandom_range(0, 2) == 0) ? !col_open[c-1] : col_open[c-1];
    for (int p = 0; p < n_pix; p++) begin
      c = p % eff;
      r = $urandom_range(0, 15);
      if (fixed) begin
        d = col_depth[c];
      end else if (r == 0) begin
        d = '0;
      end else if (r == 1) begin
        d = DEPTH_W'($urandom_range(0, DEPTH_MAX));
      end else if (r == 2) begin
        d = '1;
      end else if (col_open[c]) begin
        v = board.limit_reg + $urandom_range(0, 400);
        d = (v > DEPTH_MAX) ? '1 : DEPTH_W'(v);
      end else begin
        d = (board.limit_reg == 0) ? '0 : DEPTH_W'($urandom_range(0, board.limit_reg - 1));
      end
      send_pixel(d, p == n_pix - 1);
    end
  endtask

  initial begin : stimulus
    int n, keep_cfg, rows, cut;
    int unsigned fw, bf, be, nl;
    board = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values read back, then one short frame at the reset setting, ended before the band
    check_reg(REG_FRAME_WIDTH);
    check_reg(REG_BAND_FIRST);
    check_reg(REG_BAND_END);
    check_reg(REG_NEAR_LIMIT);
    send_frame(1'b0, BE_RST, 20);
    idle_on = 1'b1;

    // width register above the column count acts as the full width,
    // frame end inside the judging row closes the run that is still open
    settle();
    set_cfg(511, 0, 1, 0);
    fill_columns('1, 9000);
    send_frame(1'b1, 1, 24);
    // width 0 acts as a single column, single column never makes a gap
    settle();
    set_cfg(0, 0, 2, 100);
    fill_columns('1, 3000);
    send_frame(1'b1, 3, 0);
    settle();
    set_cfg(1, 0, 1, 0);
    send_frame(1'b0, 2, 0);
    // average exactly at the limit counts as free, lone free column at the edge is no gap
    settle();
    set_cfg(4, 1, 2, NL_RST);
    write_reg(REG_NEAR_LIMIT, DEPTH_MAX);
    fill_columns(4'b1011, DEPTH_MAX);
    col_depth[2] = DEPTH_MAX - 1;
    send_frame(1'b1, 2, 0);
    // three equal runs: the two earliest win
    settle();
    set_cfg(10, 0, 1, 100);
    fill_columns(10'b1011011011, 5000);
    send_frame(1'b1, 1, 0);
    // longer runs push a shorter earlier one out; zero sums stay closed at limit 0
    settle();
    write_reg(REG_NEAR_LIMIT, 0);
    fill_columns(10'b1110111011, 5000);
    send_frame(1'b1, 1, 0);
    // empty bands: end equal to first, end below first
    settle();
    set_cfg(2, 3, 3, 0);
    send_frame(1'b0, 4, 0);
    settle();
    set_cfg(2, 200, 3, 0);
    send_frame(1'b0, 3, 0);
    // frame end before the judging row, then inside it with a run still open
    settle();
    set_cfg(6, 0, 3, 100);
    fill_columns(6'b111110, 3000);
    send_frame(1'b1, 3, 9);
    send_frame(1'b1, 3, 16);
    // highest band registers, short frame that never reaches the band
    settle();
    set_cfg(2, 255, 511, 8000);
    send_frame(1'b0, 511, 6);

    // random small frames, with a setting change now and then
    keep_cfg = 0;
    n        = 0;
    while (board.pixels < ITEM_TARGET || n < RAND_FRAMES) begin
      idle_on = (keep_cfg == 0) && ($urandom_range(0, 3) != 0);
      if (n == 2) begin
        // results held back for a long stretch while frames keep coming
        settle();
        choke_req = 1'b1;
        keep_cfg  = 3;
      end else if (n == 0 || (keep_cfg == 0 && $urandom_range(0, 2) == 0)) begin
        fw = $urandom_range(0, 8);
        bf = $urandom_range(0, 2);
        be = bf + $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) be = $urandom_range(0, bf);
        case ($urandom_range(0, 7))
          0:       nl = 0;
          1:       nl = DEPTH_MAX;
          default: nl = $urandom_range(0, 3000);
        endcase
        settle();
        set_cfg(fw, bf, be, nl);
      end else if (keep_cfg > 0) begin
        keep_cfg--;
      end
      rows = ((board.end_reg > board.first_reg) ? board.end_reg : board.first_reg + 1) +
             $urandom_range(0, 1);
      cut  = ($urandom_range(0, 5) == 0) ? -1 : 0;
      send_frame(1'b0, rows, cut);
      n++;
    end

    settle();
    if (board.due_gaps.size() != 0) begin
      $error("%0d gap items never arrived", board.due_gaps.size());
      board.errors++;
    end
    $display("run covered %0d pixels in %0d frames under %0d register settings",
             board.pixels, board.frames, cfg_sets);
    $display("%0d ranked gap items compared, %0d of them holding a gap",
             board.seen, board.with_gap);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
